// File: rtl/yta_pkg.sv
// ----------------------------------------------------------------------------
// yta_pkg
// shared types and constants of the yuv to argb pixel converter
// ----------------------------------------------------------------------------
package yta_pkg;

  localparam int unsigned CHAN_WIDTH = 8;
  localparam int unsigned SHIFT_WIDTH = 4;

  localparam logic [CHAN_WIDTH-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } yta_pipe_ctl_t;

endpackage

// File: rtl/yta_stream_if.sv
// ----------------------------------------------------------------------------
// yta stream interfaces
// valid/ready channels for yuv samples in and argb pixels out
// ----------------------------------------------------------------------------
interface yta_yuv_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] luma;
  logic [SAMPLE_WIDTH-1:0] chroma_u;
  logic [SAMPLE_WIDTH-1:0] chroma_v;

  modport source (output valid, output luma, output chroma_u, output chroma_v, input ready);
  modport sink   (input valid, input luma, input chroma_u, input chroma_v, output ready);
endinterface

interface yta_argb_if;
  logic                            valid;
  logic                            ready;
  logic [yta_pkg::CHAN_WIDTH-1:0]  blue;
  logic [yta_pkg::CHAN_WIDTH-1:0]  green;
  logic [yta_pkg::CHAN_WIDTH-1:0]  red;
  logic [yta_pkg::CHAN_WIDTH-1:0]  alpha;

  modport source (output valid, output blue, output green, output red, output alpha, input ready);
  modport sink   (input valid, input blue, input green, input red, input alpha, output ready);
endinterface

// File: rtl/yta_datapath.sv
// ----------------------------------------------------------------------------
// yta_datapath
// four-stage bt.601 limited-range conversion: byte extract, multiply,
// channel sums, floor shift and saturate
// ----------------------------------------------------------------------------
module yta_datapath #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  yta_pkg::yta_pipe_ctl_t              ctl,
  input  logic [yta_pkg::SHIFT_WIDTH-1:0]     shift,
  input  logic [SAMPLE_WIDTH-1:0]             luma,
  input  logic [SAMPLE_WIDTH-1:0]             chroma_u,
  input  logic [SAMPLE_WIDTH-1:0]             chroma_v,
  output logic [yta_pkg::CHAN_WIDTH-1:0]      blue,
  output logic [yta_pkg::CHAN_WIDTH-1:0]      green,
  output logic [yta_pkg::CHAN_WIDTH-1:0]      red
);

  localparam logic [30:0]        LUMA_GAIN  = 31'd18997;
  localparam logic signed [17:0] LUMA_BIAS  = -18'sd1160;
  localparam logic signed [8:0]  CHROMA_MID = 9'sd128;
  localparam logic signed [14:0] GAIN_UG    = 15'sd25;
  localparam logic signed [14:0] GAIN_VG    = 15'sd52;
  localparam logic signed [14:0] GAIN_VR    = 15'sd102;

  function automatic logic [7:0] saturate(input logic signed [17:0] sum);
    logic signed [17:0] q;
    q = sum >>> 6;
    if (q < 0) begin
      saturate = 8'd0;
    end else if (q > 18'sd255) begin
      saturate = 8'd255;
    end else begin
      saturate = q[7:0];
    end
  endfunction

  // stage 1: shifted sample bytes, chroma centered
  logic [7:0]        y_r;
  logic signed [8:0] u_r, v_r;
  logic [7:0]        y_nxt, u_byte, v_byte;

  assign y_nxt  = 8'(luma >> shift);
  assign u_byte = 8'(chroma_u >> shift);
  assign v_byte = 8'(chroma_v >> shift);

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      y_r <= y_nxt;
      u_r <= $signed({1'b0, u_byte}) - CHROMA_MID;
      v_r <= $signed({1'b0, v_byte}) - CHROMA_MID;
    end
  end

  // stage 2: luma scale and chroma products
  logic [14:0]        yhi_r;
  logic signed [15:0] cb_r;
  logic signed [14:0] cg_r, cr_r;
  logic [30:0]        yprod_nxt;
  logic signed [14:0] cg_nxt, cr_nxt;

  assign yprod_nxt = {15'd0, y_r, y_r} * LUMA_GAIN;
  assign cg_nxt    = 15'(u_r) * GAIN_UG + 15'(v_r) * GAIN_VG;
  assign cr_nxt    = 15'(v_r) * GAIN_VR;

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      yhi_r <= yprod_nxt[30:16];
      cb_r  <= {u_r, 7'd0};
      cg_r  <= cg_nxt;
      cr_r  <= cr_nxt;
    end
  end

  // stage 3: channel sums
  logic signed [17:0] b_r, g_r, r_r;
  logic signed [17:0] ylum;

  assign ylum = $signed({3'd0, yhi_r}) + LUMA_BIAS;

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      b_r <= ylum + 18'(cb_r);
      g_r <= ylum - 18'(cg_r);
      r_r <= ylum + 18'(cr_r);
    end
  end

  // stage 4: output register
  logic [7:0] blue_r, green_r, red_r;

  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      blue_r  <= saturate(b_r);
      green_r <= saturate(g_r);
      red_r   <= saturate(r_r);
    end
  end

  assign blue  = blue_r;
  assign green = green_r;
  assign red   = red_r;

endmodule

// File: rtl/yuv_to_argb_pixel.sv
// ----------------------------------------------------------------------------
// yuv_to_argb_pixel
// each pixel moves through the byte, product, sum and output stage registers in order
// throughput: one pixel per cycle while the output is not stalled, set by the four-stage conversion pipeline
// a stalled output holds its pixel while free stages keep filling
// reset clears all stage valid bits and sets shift_r to 0
// ----------------------------------------------------------------------------
module yuv_to_argb_pixel #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [yta_pkg::SHIFT_WIDTH-1:0]  cfg_wr_data,
  yta_yuv_if.sink                          in_pix,
  yta_argb_if.source                       out_pix
);

  logic [yta_pkg::SHIFT_WIDTH-1:0] shift_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  yta_pkg::yta_pipe_ctl_t ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
    end else if (cfg_wr_en) begin
      shift_r <= cfg_wr_data;
    end
  end

  assign rdy4 = !v4_r || out_pix.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign ctl.ld1 = rdy1;
  assign ctl.ld2 = rdy2;
  assign ctl.ld3 = rdy3;
  assign ctl.ld4 = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_pix.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  yta_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .ctl      (ctl),
    .shift    (shift_r),
    .luma     (in_pix.luma),
    .chroma_u (in_pix.chroma_u),
    .chroma_v (in_pix.chroma_v),
    .blue     (out_pix.blue),
    .green    (out_pix.green),
    .red      (out_pix.red)
  );

  assign in_pix.ready  = rdy1;
  assign out_pix.valid = v4_r;
  assign out_pix.alpha = yta_pkg::ALPHA_OPAQUE;

endmodule

// File: rtl/yta_checker.sv
// ----------------------------------------------------------------------------
// yta_checker
// port-level checks of the yuv to argb pixel converter
// ----------------------------------------------------------------------------
module yta_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [yta_pkg::CHAN_WIDTH-1:0]  out_blue,
  input logic [yta_pkg::CHAN_WIDTH-1:0]  out_green,
  input logic [yta_pkg::CHAN_WIDTH-1:0]  out_red,
  input logic [yta_pkg::CHAN_WIDTH-1:0]  out_alpha
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // an empty output stage never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while output stage empty");

  a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alpha == yta_pkg::ALPHA_OPAQUE)
    else $error("alpha not opaque");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_blue) && $stable(out_green)
      && $stable(out_red))
    else $error("stalled pixel changed");

  // an input transfer leaves the output stage occupied once it has moved through the stage registers
  a_in_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##4 out_valid)
    else $error("input transfer did not reach the output stage");

endmodule

bind yuv_to_argb_pixel yta_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .out_blue  (out_pix.blue),
  .out_green (out_pix.green),
  .out_red   (out_pix.red),
  .out_alpha (out_pix.alpha)
);
